// File: src/fkc_pkg.sv
// Shared types, codes and constants for the four-function key calculator.
package fkc_pkg;

    localparam int OUT_WIDTH = 32;

    // Keypress commands
    localparam logic [2:0] CMD_DIGIT     = 3'd0;
    localparam logic [2:0] CMD_OPER      = 3'd1;
    localparam logic [2:0] CMD_EQUALS    = 3'd2;
    localparam logic [2:0] CMD_CLEAR     = 3'd3;
    localparam logic [2:0] CMD_CLEAR_ENT = 3'd4;
    localparam logic [2:0] CMD_TOGGLE    = 3'd5;
    localparam logic [2:0] CMD_BACKSPACE = 3'd6;

    // Pending operator codes
    localparam logic [2:0] PEND_NONE = 3'd0;
    localparam logic [2:0] PEND_ADD  = 3'd1;
    localparam logic [2:0] PEND_SUB  = 3'd2;
    localparam logic [2:0] PEND_MUL  = 3'd3;
    localparam logic [2:0] PEND_DIV  = 3'd4;

    localparam logic [3:0] DIGIT_MAX = 4'd9;

    typedef struct packed {
        logic [2:0] command;
        logic [3:0] digit;
        logic [1:0] operator_code;
    } fkc_in_t;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] display_value;
        logic                        display_error;
        logic [2:0]                  pending_operator;
        logic signed [OUT_WIDTH-1:0] first_operand;
        logic                        waiting_for_second;
        logic                        history_valid;
        logic signed [OUT_WIDTH-1:0] history_first;
        logic signed [OUT_WIDTH-1:0] history_second;
        logic [1:0]                  history_operator;
    } fkc_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CALC,
        ST_COMMIT
    } fkc_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic start_calc;
        logic commit;
    } fkc_ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic need_calc;
        logic calc_done;
    } fkc_sts_t;

endpackage

// File: src/four_function_key_calculator_unit.sv
// Top level of the four-function key calculator.
// One keypress is taken per transfer on the key channel and exactly one result
// transfer follows on the result channel, carrying the display, the pending
// operator, the left operand, the waiting flag and, after an equals that
// completed a calculation, the operands and operator of that calculation.
// Operators chain left to right, arithmetic wraps at VALUE_WIDTH bits, division
// truncates toward zero and division by zero shows Error with value 0. Results
// wider or narrower than 32 bits are truncated or zero-extended to the fields.
// Sequence: a keypress that needs no multiply or divide passes from the idle
// state, where it is taken, through execute to commit, and the key channel is
// ready again once the sequencer is back in idle. Multiply, divide and backspace
// (the display magnitude times the reciprocal of ten) run through a shared
// bit-serial unit, which adds a calculate state between execute and commit; the
// loop in that unit takes one quotient or product bit per cycle. A new keypress
// is taken as soon as the previous one has been committed to the result
// register, even while that result still waits for its transfer; the next
// commit then waits for the register to free.
module four_function_key_calculator_unit #(
    parameter int ENTRY_DIGITS = 9,
    parameter int VALUE_WIDTH  = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              key_valid,
    output logic              key_ready,
    input  fkc_pkg::fkc_in_t  key,
    output logic              result_valid,
    input  logic              result_ready,
    output fkc_pkg::fkc_out_t result
);

    import fkc_pkg::*;

    // Command and status between sequencer and datapath
    fkc_ctl_t ctl;
    fkc_sts_t sts;

    fkc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .key_valid   (key_valid),
        .key_ready   (key_ready),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .sts         (sts),
        .ctl         (ctl)
    );

    fkc_datapath #(
        .ENTRY_DIGITS(ENTRY_DIGITS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .key   (key),
        .ctl   (ctl),
        .sts   (sts),
        .result(result)
    );

endmodule

// File: src/fkc_arith.sv
// Iterative shift-add multiplier with full product and restoring divider, one bit per cycle.
module fkc_arith #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   is_div,
    input  logic [VALUE_WIDTH-1:0] opa,
    input  logic [VALUE_WIDTH-1:0] opb,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] product,
    output logic [VALUE_WIDTH-1:0] product_hi,
    output logic [VALUE_WIDTH-1:0] quotient
);

    localparam int VW = VALUE_WIDTH;
    localparam int CW = $clog2(VW);

    logic          busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          div_reg, div_next;
    logic [VW-1:0] p_reg, p_next;
    logic [VW-1:0] a_reg, a_next;
    logic [VW-1:0] b_reg, b_next;
    logic [VW:0]   rem_sh;
    logic [VW:0]   diff;
    logic [VW:0]   madd;

    assign done       = busy_reg && (cnt_reg == '0);
    assign product    = a_reg;
    assign product_hi = p_reg;
    assign quotient   = a_reg;

    assign rem_sh = {p_reg, a_reg[VW-1]};
    assign diff   = rem_sh - {1'b0, b_reg};
    assign madd   = {1'b0, p_reg} + (a_reg[0] ? {1'b0, b_reg} : '0);

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        p_next    = p_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(VW - 1);
            div_next  = is_div;
            p_next    = '0;
            a_next    = opa;
            b_next    = opb;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            if (div_reg)
            begin
                // restore when the trial subtract borrows
                if (!diff[VW])
                begin
                    p_next = diff[VW-1:0];
                end
                else
                begin
                    p_next = rem_sh[VW-1:0];
                end
                a_next = {a_reg[VW-2:0], ~diff[VW]};
            end
            else
            begin
                // shift the partial sum right into the multiplier bits
                p_next = madd[VW:1];
                a_next = {madd[0], a_reg[VW-1:1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        p_reg   <= p_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

endmodule

// File: src/fkc_datapath.sv
// Calculator state, keypress decode, update logic and result register.
module fkc_datapath #(
    parameter int ENTRY_DIGITS = 9,
    parameter int VALUE_WIDTH  = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  fkc_pkg::fkc_in_t key,
    input  fkc_pkg::fkc_ctl_t ctl,
    output fkc_pkg::fkc_sts_t sts,
    output fkc_pkg::fkc_out_t result
);

    import fkc_pkg::*;

    localparam int VW = VALUE_WIDTH;

    function automatic logic [63:0] pow10(input int n);
        logic [63:0] v;
        v = 64'd1;
        for (int i = 0; i < n; i++)
        begin
            v = v * 64'd10;
        end
        return v;
    endfunction

    // ceil(2^shift / 10); with shift = VW + 3 the top of m * RECIP10 is m / 10
    function automatic logic [VW-1:0] recip10(input int shift);
        logic [VW+3:0] scale;
        scale        = '0;
        scale[shift] = 1'b1;
        return VW'(scale / 10 + 1);
    endfunction

    // an entry below this magnitude still has room for one more digit
    localparam logic [63:0] ENTRY_LIMIT = pow10(ENTRY_DIGITS - 1);
    localparam logic [VW-1:0] ONE = VW'(1);
    localparam logic [VW-1:0] RECIP10 = recip10(VW + 3);

    // Keypress held for the duration of the item
    logic [2:0] cmd_reg;
    logic [3:0] dig_reg;
    logic [1:0] opc_reg;

    // Architectural state
    logic [VW-1:0] acc_reg, acc_next;
    logic [VW-1:0] disp_reg, disp_next;
    logic          err_reg, err_next;
    logic [2:0]    pend_reg, pend_next;
    logic          wait_reg, wait_next;
    logic          jc_reg, jc_next;

    fkc_out_t out_reg, out_next;

    logic [VW-1:0] cur, cur_mag, acc_mag, disp_mag;
    logic [VW-1:0] product, product_hi, quotient, quot_neg, back_mag, back_val;
    logic [VW-1:0] sdiv, apply_res, entry_mag, entry_val;
    logic          apply_go, div_zero, is_back, calc_div, calc_done;
    logic [VW-1:0] calc_a, calc_b;
    logic          hv;
    logic [VW-1:0] hf, hs;
    logic [1:0]    ho;
    logic [VW-1:0] shown;
    logic [VW+OUT_WIDTH-1:0] ext_shown, ext_acc, ext_hf, ext_hs;

    assign cur      = err_reg ? '0 : disp_reg;
    assign cur_mag  = cur[VW-1] ? ('0 - cur) : cur;
    assign acc_mag  = acc_reg[VW-1] ? ('0 - acc_reg) : acc_reg;
    assign disp_mag = disp_reg[VW-1] ? ('0 - disp_reg) : disp_reg;

    assign apply_go = (pend_reg != PEND_NONE) && !wait_reg;
    assign div_zero = (pend_reg == PEND_DIV) && (cur == '0);
    assign is_back  = (cmd_reg == CMD_BACKSPACE);

    assign sts.need_calc =
        (((cmd_reg == CMD_OPER) || (cmd_reg == CMD_EQUALS)) && apply_go &&
         ((pend_reg == PEND_MUL) || ((pend_reg == PEND_DIV) && (cur != '0)))) ||
        (is_back && !jc_reg && !err_reg);
    assign sts.calc_done = calc_done;

    // Operands for the shared unit: signed product, magnitudes for divide, or
    // the display magnitude times the reciprocal of ten for backspace
    assign calc_div = !is_back && (pend_reg == PEND_DIV);
    assign calc_a   = is_back ? disp_mag : ((pend_reg == PEND_MUL) ? acc_reg : acc_mag);
    assign calc_b   = is_back ? RECIP10 : ((pend_reg == PEND_MUL) ? cur : cur_mag);

    fkc_arith #(
        .VALUE_WIDTH(VW)
    ) u_arith (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ctl.start_calc),
        .is_div    (calc_div),
        .opa       (calc_a),
        .opb       (calc_b),
        .done      (calc_done),
        .product   (product),
        .product_hi(product_hi),
        .quotient  (quotient)
    );

    assign quot_neg = '0 - quotient;
    assign sdiv     = (acc_reg[VW-1] != cur[VW-1]) ? quot_neg : quotient;
    assign back_mag = {3'b000, product_hi[VW-1:3]};
    assign back_val = disp_reg[VW-1] ? ('0 - back_mag) : back_mag;

    always_comb
    begin
        case (pend_reg)
            PEND_ADD: apply_res = acc_reg + cur;
            PEND_SUB: apply_res = acc_reg - cur;
            PEND_MUL: apply_res = product;
            PEND_DIV: apply_res = sdiv;
            default:  apply_res = acc_reg;
        endcase
    end

    // Append a digit: m * 10 + d as two shifts and adds
    assign entry_mag = {disp_mag[VW-4:0], 3'b000} + {disp_mag[VW-2:0], 1'b0} +
                       {{(VW-4){1'b0}}, dig_reg};
    assign entry_val = disp_reg[VW-1] ? ('0 - entry_mag) : entry_mag;

    always_comb
    begin
        acc_next  = acc_reg;
        disp_next = disp_reg;
        err_next  = err_reg;
        pend_next = pend_reg;
        wait_next = wait_reg;
        jc_next   = jc_reg;
        hv        = 1'b0;
        hf        = '0;
        hs        = '0;
        ho        = '0;
        case (cmd_reg)
            CMD_DIGIT:
            begin
                if (dig_reg <= DIGIT_MAX)
                begin
                    if (jc_reg)
                    begin
                        disp_next = {{(VW-4){1'b0}}, dig_reg};
                        jc_next   = 1'b0;
                        err_next  = 1'b0;
                    end
                    else if (err_reg || (disp_reg == '0) || wait_reg)
                    begin
                        disp_next = {{(VW-4){1'b0}}, dig_reg};
                        wait_next = 1'b0;
                        err_next  = 1'b0;
                    end
                    else if (64'(disp_mag) < ENTRY_LIMIT)
                    begin
                        disp_next = entry_val;
                    end
                end
            end
            CMD_OPER:
            begin
                if (apply_go && div_zero)
                begin
                    disp_next = '0;
                    err_next  = 1'b1;
                    acc_next  = '0;
                    pend_next = PEND_NONE;
                    wait_next = 1'b0;
                    jc_next   = 1'b1;
                end
                else
                begin
                    if (apply_go)
                    begin
                        acc_next  = apply_res;
                        disp_next = apply_res;
                        err_next  = 1'b0;
                    end
                    else
                    begin
                        acc_next = cur;
                    end
                    wait_next = 1'b1;
                    jc_next   = 1'b0;
                    pend_next = {1'b0, opc_reg} + 3'd1;
                end
            end
            CMD_EQUALS:
            begin
                if (apply_go && div_zero)
                begin
                    disp_next = '0;
                    err_next  = 1'b1;
                    acc_next  = '0;
                    pend_next = PEND_NONE;
                    wait_next = 1'b0;
                    jc_next   = 1'b1;
                end
                else if (apply_go)
                begin
                    hv        = 1'b1;
                    hf        = acc_reg;
                    hs        = cur;
                    ho        = 2'(pend_reg - PEND_ADD);
                    acc_next  = apply_res;
                    disp_next = apply_res;
                    err_next  = 1'b0;
                    pend_next = PEND_NONE;
                    wait_next = 1'b0;
                    jc_next   = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                acc_next  = '0;
                disp_next = '0;
                err_next  = 1'b0;
                pend_next = PEND_NONE;
                wait_next = 1'b0;
                jc_next   = 1'b0;
            end
            CMD_CLEAR_ENT:
            begin
                disp_next = '0;
                err_next  = 1'b0;
                jc_next   = 1'b0;
            end
            CMD_TOGGLE:
            begin
                disp_next = ~cur + ONE;
                err_next  = 1'b0;
            end
            CMD_BACKSPACE:
            begin
                if (!jc_reg)
                begin
                    if (err_reg)
                    begin
                        disp_next = '0;
                        err_next  = 1'b0;
                    end
                    else
                    begin
                        disp_next = back_val;
                    end
                end
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    // Fit values to the 32-bit result fields (zero-extend or truncate)
    assign shown     = err_next ? '0 : disp_next;
    assign ext_shown = {{OUT_WIDTH{1'b0}}, shown};
    assign ext_acc   = {{OUT_WIDTH{1'b0}}, acc_next};
    assign ext_hf    = {{OUT_WIDTH{1'b0}}, hf};
    assign ext_hs    = {{OUT_WIDTH{1'b0}}, hs};

    always_comb
    begin
        out_next.display_value      = ext_shown[OUT_WIDTH-1:0];
        out_next.display_error      = err_next;
        out_next.pending_operator   = pend_next;
        out_next.first_operand      = ext_acc[OUT_WIDTH-1:0];
        out_next.waiting_for_second = wait_next;
        out_next.history_valid      = hv;
        out_next.history_first      = ext_hf[OUT_WIDTH-1:0];
        out_next.history_second     = ext_hs[OUT_WIDTH-1:0];
        out_next.history_operator   = ho;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            disp_reg <= '0;
            err_reg  <= 1'b0;
            pend_reg <= PEND_NONE;
            wait_reg <= 1'b0;
            jc_reg   <= 1'b0;
        end
        else if (ctl.commit)
        begin
            acc_reg  <= acc_next;
            disp_reg <= disp_next;
            err_reg  <= err_next;
            pend_reg <= pend_next;
            wait_reg <= wait_next;
            jc_reg   <= jc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            cmd_reg <= key.command;
            dig_reg <= key.digit;
            opc_reg <= key.operator_code;
        end
        if (ctl.commit)
        begin
            out_reg <= out_next;
        end
    end

    assign result = out_reg;

endmodule

// File: src/fkc_ctrl.sv
// Sequencing controller: accept, decode, run the arithmetic unit, commit.
module fkc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              key_valid,
    output logic              key_ready,
    output logic              result_valid,
    input  logic              result_ready,
    input  fkc_pkg::fkc_sts_t sts,
    output fkc_pkg::fkc_ctl_t ctl
);

    import fkc_pkg::*;

    fkc_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || result_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (key_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = sts.need_calc ? ST_CALC : ST_COMMIT;
            end
            ST_CALC:
            begin
                if (sts.calc_done)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        key_ready      = 1'b0;
        ctl.load_item  = 1'b0;
        ctl.start_calc = 1'b0;
        ctl.commit     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                key_ready     = 1'b1;
                ctl.load_item = key_valid;
            end
            ST_EXEC:
            begin
                ctl.start_calc = sts.need_calc;
            end
            ST_COMMIT:
            begin
                ctl.commit = slot_free;
            end
            default:
            begin
                key_ready = 1'b0;
            end
        endcase
    end

    // Hold the result until the far side takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign result_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
